### hdl/ftm_pkg.sv
// shared types and constants for the flux to mfm word decoder
package ftm_pkg;

  localparam int WORD_W       = 16;
  localparam int TOL_W        = 6;
  localparam int CC_W         = 4;
  localparam int UNIT_W       = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam int MAX_SHIFTS   = 8;
  localparam int UNITS_PER_US = 40;
  localparam int SHIFT_W      = $clog2(MAX_SHIFTS + 1);

  // reciprocal of the cell unit, exact for every 16-bit interval
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int RECIP        = (2 ** RECIP_SHIFT + UNITS_PER_US - 1) / UNITS_PER_US;
  localparam int PROD_W       = WORD_W + RECIP_W;
  localparam int REF_W        = WORD_W + 1;
  localparam int REFU_W       = REF_W + UNIT_W;

  localparam int RESULT_LIMIT = 2;
  localparam int RES_CNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PAT   = 1'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 6'd10;
  localparam logic [WORD_W-1:0] SYNC_RESET = 16'h4489;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] pattern;
    logic [CC_W-1:0]   cell_count;
    logic              last_cell;
  } step_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] pattern;
    logic [CC_W-1:0]   cell_count;
    logic              emit;
    logic [WORD_W-1:0] emit_word;
    logic              synced;
  } step_out_t;

endpackage

### hdl/ftm_if.sv
// item channel interfaces for flux intervals and mfm words
interface ftm_flux_if;
  logic                       valid;
  logic                       ready;
  logic [ftm_pkg::WORD_W-1:0] flux_units;
  logic                       track_start;

  modport source (output valid, output flux_units, output track_start, input ready);
  modport sink   (input valid, input flux_units, input track_start, output ready);
endinterface

interface ftm_word_if;
  logic                       valid;
  logic                       ready;
  logic [ftm_pkg::WORD_W-1:0] mfm_word;
  logic                       synced;
  logic                       last;

  modport source (output valid, output mfm_word, output synced, output last, input ready);
  modport sink   (input valid, input mfm_word, input synced, input last, output ready);
endinterface

### hdl/ftm_cell_step.sv
// one mfm cell shift with sync-mark realignment and word completion
module ftm_cell_step (
  input  ftm_pkg::step_in_t            step_i,
  input  logic [ftm_pkg::WORD_W-1:0]   sync_pat_i,
  output ftm_pkg::step_out_t           step_o
);

  logic [ftm_pkg::WORD_W-1:0] w;
  logic [ftm_pkg::WORD_W-1:0] p;
  logic [ftm_pkg::CC_W-1:0]   cc;
  logic [ftm_pkg::CC_W:0]     cc_inc;
  logic                       syn;

  always_comb begin
    w   = step_i.word | {{(ftm_pkg::WORD_W-1){1'b0}}, step_i.last_cell};
    p   = step_i.pattern | {{(ftm_pkg::WORD_W-1){1'b0}}, step_i.last_cell};
    cc  = step_i.cell_count;
    syn = 1'b0;
    // sync mark: realign so the word closes on this cell
    if (p == sync_pat_i) begin
      p   = '0;
      w   = w << ({ftm_pkg::CC_W{1'b1}} - cc);
      cc  = {ftm_pkg::CC_W{1'b1}};
      syn = 1'b1;
    end
    p      = p << 1;
    cc_inc = {1'b0, cc} + 1'b1;
    step_o.emit      = cc_inc[ftm_pkg::CC_W];
    step_o.emit_word = w;
    step_o.synced    = syn;
    if (cc_inc[ftm_pkg::CC_W]) begin
      w = '0;
    end
    step_o.word       = w << 1;
    step_o.pattern    = p;
    step_o.cell_count = cc_inc[ftm_pkg::CC_W-1:0];
  end

endmodule

### hdl/flux_to_mfm_word_decoder_unit.sv
// flux interval to mfm word decoder top level with sequencer
// per item: divide, reference multiply and compare steps, then n shifts, then a flush step
// n = shifts, n <= MAX_SHIFTS; a new item is accepted only in idle, after the last one's flush
// the single cell-step unit runs once per cycle per shift, unless a busy output stalls it
// a busy output also holds the flush step
// reset: asynchronous active low, clears state, registers to defaults, no clearing pass
module flux_to_mfm_word_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ftm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ftm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  ftm_flux_if.sink                          flux_i,
  ftm_word_if.source                        word_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_REF   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // configuration registers
  logic [ftm_pkg::TOL_W-1:0]  tol_q;
  logic [ftm_pkg::WORD_W-1:0] sync_q;

  // decoder state
  logic [2:0]                  state_q, state_d;
  logic [ftm_pkg::WORD_W-1:0]  word_q;
  logic [ftm_pkg::WORD_W-1:0]  pat_q;
  logic [ftm_pkg::CC_W-1:0]    cc_q;

  // interval rounding
  logic [ftm_pkg::WORD_W-1:0]  units_q;
  logic [ftm_pkg::PROD_W-1:0]  prod_q;
  logic [ftm_pkg::REF_W-1:0]   ref_q;
  logic [ftm_pkg::REFU_W-1:0]  refu_q;
  logic [ftm_pkg::REF_W-1:0]   ref_d;
  logic [ftm_pkg::REFU_W-1:0]  units_ext;
  logic [ftm_pkg::REFU_W-1:0]  tol_ext;
  logic                        short_cell;
  logic [ftm_pkg::WORD_W-1:0]  half_ref;
  logic [ftm_pkg::WORD_W-1:0]  shifts_raw;
  logic [ftm_pkg::SHIFT_W-1:0] shifts_d;

  // shift loop
  logic [ftm_pkg::SHIFT_W-1:0] shifts_q;
  logic [ftm_pkg::SHIFT_W-1:0] idx_q;
  ftm_pkg::step_in_t           step_in;
  ftm_pkg::step_out_t          step_out;

  // result handling: one pending word, one output register
  logic                          pend_valid_q;
  logic [ftm_pkg::WORD_W-1:0]    pend_word_q;
  logic                          pend_synced_q;
  logic [ftm_pkg::RES_CNT_W-1:0] res_cnt_q;
  logic                          out_valid_q;
  logic [ftm_pkg::WORD_W-1:0]    out_word_q;
  logic                          out_synced_q;
  logic                          out_last_q;

  logic accept;
  logic out_free;
  logic need_push;
  logic stall;
  logic push_shift;
  logic push_flush;
  logic advance;
  logic final_shift;

  assign accept   = flux_i.valid && flux_i.ready;
  assign out_free = !out_valid_q || word_o.ready;

  assign flux_i.ready    = (state_q == S_IDLE);
  assign word_o.valid    = out_valid_q;
  assign word_o.mfm_word = out_word_q;
  assign word_o.synced   = out_synced_q;
  assign word_o.last     = out_last_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= ftm_pkg::TOL_RESET;
      sync_q <= ftm_pkg::SYNC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftm_pkg::REG_WINDOW_TOL: tol_q  <= cfg_data_i[ftm_pkg::TOL_W-1:0];
        ftm_pkg::REG_SYNC_PAT:   sync_q <= cfg_data_i[ftm_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // reference cell: even number of microseconds, quotient from the reciprocal product
  assign ref_d = ({1'b0, prod_q[ftm_pkg::RECIP_SHIFT +: ftm_pkg::WORD_W]} + 1'b1)
                 & ~{{(ftm_pkg::REF_W-1){1'b0}}, 1'b1};

  // delay below the window gives one shift fewer; above the window rounds the same as ref
  assign units_ext  = {{(ftm_pkg::REFU_W-ftm_pkg::WORD_W){1'b0}}, units_q};
  assign tol_ext    = {{(ftm_pkg::REFU_W-ftm_pkg::TOL_W){1'b0}}, tol_q};
  assign short_cell = (units_ext + tol_ext) < refu_q;
  assign half_ref   = ref_q[ftm_pkg::REF_W-1:1];
  assign shifts_raw = half_ref - {{(ftm_pkg::WORD_W-1){1'b0}}, short_cell};
  assign shifts_d   = (shifts_raw > ftm_pkg::WORD_W'(ftm_pkg::MAX_SHIFTS))
                      ? ftm_pkg::SHIFT_W'(ftm_pkg::MAX_SHIFTS)
                      : shifts_raw[ftm_pkg::SHIFT_W-1:0];

  // shared cell-step unit
  assign final_shift       = (idx_q == shifts_q - 1'b1);
  assign step_in.word       = word_q;
  assign step_in.pattern    = pat_q;
  assign step_in.cell_count = cc_q;
  assign step_in.last_cell  = final_shift;

  ftm_cell_step u_step (
    .step_i     (step_in),
    .sync_pat_i (sync_q),
    .step_o     (step_out)
  );

  // words past the result limit are dropped, the state still advances
  assign need_push  = step_out.emit && (res_cnt_q < ftm_pkg::RES_CNT_W'(ftm_pkg::RESULT_LIMIT));
  assign stall      = need_push && pend_valid_q && !out_free;
  assign advance    = (state_q == S_SHIFT) && !stall;
  assign push_shift = advance && need_push && pend_valid_q;
  assign push_flush = (state_q == S_FLUSH) && pend_valid_q && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_DIV;
      S_DIV:   state_d = S_REF;
      S_REF:   state_d = S_CMP;
      S_CMP:   state_d = (shifts_d == '0) ? S_FLUSH : S_SHIFT;
      S_SHIFT: if (advance && final_shift) state_d = S_FLUSH;
      S_FLUSH: if (!pend_valid_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // rounding datapath, one multiply per step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      units_q <= flux_i.flux_units;
    end
    if (state_q == S_DIV) begin
      prod_q <= {{ftm_pkg::RECIP_W{1'b0}}, units_q} * ftm_pkg::PROD_W'(ftm_pkg::RECIP);
    end
    if (state_q == S_REF) begin
      ref_q  <= ref_d;
      refu_q <= {{ftm_pkg::UNIT_W{1'b0}}, ref_d} * ftm_pkg::REFU_W'(ftm_pkg::UNITS_PER_US);
    end
  end

  // cell state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q       <= '0;
      pat_q        <= '0;
      cc_q         <= '0;
      shifts_q     <= '0;
      idx_q        <= '0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        res_cnt_q <= '0;
        if (flux_i.track_start) begin
          word_q <= '0;
          pat_q  <= '0;
          cc_q   <= '0;
        end
      end
      if (state_q == S_CMP) begin
        shifts_q <= shifts_d;
        idx_q    <= '0;
      end
      if (advance) begin
        word_q <= step_out.word;
        pat_q  <= step_out.pattern;
        cc_q   <= step_out.cell_count;
        idx_q  <= idx_q + 1'b1;
        if (need_push) begin
          pend_valid_q <= 1'b1;
          res_cnt_q    <= res_cnt_q + 1'b1;
        end
      end
      if (push_flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && need_push) begin
      pend_word_q   <= step_out.emit_word;
      pend_synced_q <= step_out.synced;
    end
  end

  // output register: a pending word leaves as non-last when another follows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_shift || push_flush) begin
      out_valid_q <= 1'b1;
    end else if (word_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_shift || push_flush) begin
      out_word_q   <= pend_word_q;
      out_synced_q <= pend_synced_q;
      out_last_q   <= push_flush;
    end
  end

endmodule

### hdl/ftm_checker.sv
// port-level checks for the flux to mfm word decoder, bound to the top level
module ftm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ftm_pkg::WORD_W-1:0] out_word_i,
  input logic                       out_last_i
);

  // a stalled word keeps its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) && $stable(out_last_i))
    else $error("stalled output word changed");

  // an accepted item keeps the input closed through the rounding steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("input reopened during interval rounding");

  // a word that is not last means its item is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("non-last word seen while idle");

endmodule

bind flux_to_mfm_word_decoder_unit ftm_checker u_ftm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (flux_i.valid),
  .in_ready_i  (flux_i.ready),
  .out_valid_i (word_o.valid),
  .out_ready_i (word_o.ready),
  .out_word_i  (word_o.mfm_word),
  .out_last_i  (word_o.last)
);

### tb/sv/flux_to_mfm_word_decoder_unit_tb.sv
// self-checking testbench for the flux to mfm word decoder: directed table, then random traffic
`timescale 1ns / 100ps

module flux_to_mfm_word_decoder_unit_tb;

  // one expected output item
  typedef struct packed {
    logic [ftm_pkg::WORD_W-1:0] word;
    logic                       synced;
    logic                       last;
  } mfm_word_t;

  // directed row: flux item plus an optional hand-written expectation
  typedef struct packed {
    logic [ftm_pkg::WORD_W-1:0] flux;
    logic                       start;
    logic                       typed;     // expectation typed in below instead of predicted
    logic                       has_word;  // typed row emits exactly one word
    logic [ftm_pkg::WORD_W-1:0] word;
    logic                       synced;
  } flux_row_t;

  localparam int N_ROWS   = 24;
  localparam int SETTLE   = 20;   // longer than a result-less item stays in flight
  localparam int IDLE_PCT = 10;

  // cell counts of the sync mark run: 01 0001 001 0001 001 = 4489
  localparam logic [4:0][3:0] SYNC_CELLS = {4'd2, 4'd4, 4'd3, 4'd4, 4'd3};

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ftm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ftm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ftm_flux_if flux_if ();
  ftm_word_if word_if ();

  flux_to_mfm_word_decoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .flux_i     (flux_if),
    .word_o     (word_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the configuration and the decoder state
  logic [ftm_pkg::TOL_W-1:0]  tol_q;
  logic [ftm_pkg::WORD_W-1:0] sync_q;
  logic [ftm_pkg::WORD_W-1:0] word_sr;
  logic [ftm_pkg::WORD_W-1:0] pattern_sr;
  int                         cells_in_word;

  mfm_word_t words_due[$];    // expected words, oldest first
  mfm_word_t fresh_words[$];  // words caused by the item just accepted
  flux_row_t dir_rows [N_ROWS];
  int        fail_count = 0;
  bit        quiet = 1'b0;    // no idling on either side while set

  // round an interval to its cell delay in microseconds
  function automatic int cell_delay(input logic [ftm_pkg::WORD_W-1:0] units);
    int cell_ref;
    int center_units;
    cell_ref     = ((int'(units) / ftm_pkg::UNITS_PER_US) + 1) & ~1;
    center_units = cell_ref * ftm_pkg::UNITS_PER_US;
    if (int'(units) < center_units - int'(tol_q)) return cell_ref - 1;
    if (int'(units) > center_units + int'(tol_q)) return cell_ref + 1;
    return cell_ref;
  endfunction

  // advance the predicted state by one item, words land in fresh_words
  task automatic decode_flux(input logic [ftm_pkg::WORD_W-1:0] units, input logic start);
    int        shifts;
    bit        hit;
    mfm_word_t w;
    fresh_words.delete();
    if (start) begin
      word_sr       = '0;
      pattern_sr    = '0;
      cells_in_word = 0;
    end
    shifts = cell_delay(units) / 2;
    if (shifts > ftm_pkg::MAX_SHIFTS) shifts = ftm_pkg::MAX_SHIFTS;
    for (int j = 0; j < shifts; j++) begin
      hit = 1'b0;
      // the flux reversal itself lands on the last cell
      if (j == shifts - 1) begin
        word_sr[0]    = 1'b1;
        pattern_sr[0] = 1'b1;
      end
      // sync mark: realign and force the word boundary now
      if (pattern_sr == sync_q) begin
        pattern_sr    = '0;
        word_sr       = word_sr << (15 - cells_in_word);
        cells_in_word = 15;
        hit           = 1'b1;
      end
      pattern_sr    = pattern_sr << 1;
      cells_in_word = cells_in_word + 1;
      if (cells_in_word >= 16) begin
        // words beyond the per-item limit are dropped, state still moves
        if (fresh_words.size() < ftm_pkg::RESULT_LIMIT) begin
          w.word   = word_sr;
          w.synced = hit;
          w.last   = 1'b0;
          fresh_words.push_back(w);
        end
        word_sr       = '0;
        cells_in_word = 0;
      end
      word_sr = word_sr << 1;
    end
    if (fresh_words.size() > 0) begin
      w      = fresh_words.pop_back();
      w.last = 1'b1;
      fresh_words.push_back(w);
    end
  endtask

  // hand one item to the block, then book what it should produce
  task automatic send_flux(input logic [ftm_pkg::WORD_W-1:0] units, input logic start,
                           input logic typed, input logic has_word,
                           input logic [ftm_pkg::WORD_W-1:0] word, input logic synced);
    mfm_word_t w;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      flux_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    flux_if.valid       <= 1'b1;
    flux_if.flux_units  <= units;
    flux_if.track_start <= start;
    @(posedge clk_i);
    while (!flux_if.ready) @(posedge clk_i);
    decode_flux(units, start);
    if (typed) begin
      if (has_word) begin
        w.word   = word;
        w.synced = synced;
        w.last   = 1'b1;
        words_due.push_back(w);
      end
    end else begin
      foreach (fresh_words[k]) words_due.push_back(fresh_words[k]);
    end
  endtask

  // interval for n cells, jittered by up to spread units either way
  function automatic logic [ftm_pkg::WORD_W-1:0] mfm_flux(input int n, input int spread);
    int units;
    units = n * 2 * ftm_pkg::UNITS_PER_US + $urandom_range(2 * spread) - spread;
    if (units < 0) units = 0;
    return units[ftm_pkg::WORD_W-1:0];
  endfunction

  // drain: nothing queued, then let any result-less item finish
  task automatic settle();
    flux_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ftm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ftm_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ftm_pkg::REG_WINDOW_TOL) tol_q = val[ftm_pkg::TOL_W-1:0];
    else sync_q = val;
  endtask

  task automatic set_phase(input int tol, input logic [ftm_pkg::WORD_W-1:0] pattern);
    settle();
    write_reg(ftm_pkg::REG_WINDOW_TOL, ftm_pkg::CFG_DATA_W'(tol));
    write_reg(ftm_pkg::REG_SYNC_PAT, pattern);
  endtask

  // random traffic, mostly well-formed mfm runs with random content
  task automatic run_random(input int count);
    int   sent;
    int   pick;
    int   n;
    logic start;
    sent = 0;
    while (sent < count) begin
      pick  = $urandom_range(99);
      start = ($urandom_range(99) < 3);
      if (pick < 10) begin
        // full sync mark run, clean timing
        for (int k = 4; k >= 0; k--)
          send_flux(mfm_flux(int'(SYNC_CELLS[k]), int'(tol_q)), 1'b0, 1'b0, 1'b0, '0, 1'b0);
        sent += 5;
      end else if (pick < 14) begin
        // long run of single cells, lets an all-ones pattern build up
        for (int k = 0; k < 17; k++)
          send_flux(mfm_flux(1, int'(tol_q)), 1'b0, 1'b0, 1'b0, '0, 1'b0);
        sent += 17;
      end else if (pick < 80) begin
        // regular 4/6/8 us cell, sometimes jittered past the window
        n = $urandom_range(2, 4);
        if ($urandom_range(3) == 0)
          send_flux(mfm_flux(n, int'(tol_q) + 4), start, 1'b0, 1'b0, '0, 1'b0);
        else
          send_flux(mfm_flux(n, int'(tol_q)), start, 1'b0, 1'b0, '0, 1'b0);
        sent++;
      end else if (pick < 88) begin
        send_flux(ftm_pkg::WORD_W'($urandom_range(65535)), start, 1'b0, 1'b0, '0, 1'b0);
        sent++;
      end else if (pick < 94) begin
        // short interval noise, mostly no shifts at all, not counted
        send_flux(ftm_pkg::WORD_W'($urandom_range(2 * ftm_pkg::UNITS_PER_US - 1)), start,
                  1'b0, 1'b0, '0, 1'b0);
      end else begin
        // long intervals up to saturation
        n = $urandom_range(5, 8);
        if ($urandom_range(1) == 0)
          send_flux(mfm_flux(n, int'(tol_q) + 4), start, 1'b0, 1'b0, '0, 1'b0);
        else
          send_flux(ftm_pkg::WORD_W'($urandom_range(65535, 640)), start,
                    1'b0, 1'b0, '0, 1'b0);
        sent++;
      end
    end
  endtask

  // receiver stalls at random unless in a quiet stretch
  always @(posedge clk_i) word_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    mfm_word_t due;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected item: mfm_word %h synced %b last %b",
               word_if.mfm_word, word_if.synced, word_if.last);
        fail_count++;
      end else begin
        due = words_due.pop_front();
        if (word_if.mfm_word !== due.word) begin
          $error("mfm_word: expected %h, got %h", due.word, word_if.mfm_word);
          fail_count++;
        end
        if (word_if.synced !== due.synced) begin
          $error("synced: expected %b, got %b", due.synced, word_if.synced);
          fail_count++;
        end
        if (word_if.last !== due.last) begin
          $error("last: expected %b, got %b", due.last, word_if.last);
          fail_count++;
        end
      end
    end
  end

  // overall limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("** flux_to_mfm_word_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = ftm_pkg::REG_WINDOW_TOL;
    cfg_data_i          = '0;
    flux_if.valid       = 1'b0;
    flux_if.flux_units  = '0;
    flux_if.track_start = 1'b0;
    tol_q               = ftm_pkg::TOL_RESET;
    sync_q              = ftm_pkg::SYNC_RESET;
    word_sr             = '0;
    pattern_sr          = '0;
    cells_in_word       = 0;

    // flux, start, typed, has_word, word, synced
    dir_rows = '{
      // short intervals at reset settings: delay 0 or 1, nothing shifted
      '{16'd0,     1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd10,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd11,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd69,    1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      // two saturated intervals fill one word: 8 cells each
      '{16'hFFFF,  1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF,  1'b0, 1'b1, 1'b1, 16'h0101, 1'b0},
      // sync mark from a clean start, forced boundary
      '{16'd160,   1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd320,   1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd240,   1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd320,   1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'd240,   1'b0, 1'b1, 1'b1, 16'h4489, 1'b1},
      // window edges around the 4 us cell and the smallest cells
      '{16'd70,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd80,    1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd119,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd120,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd149,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd150,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd170,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'd171,   1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      // field extremes and alternating bits
      '{16'h8000,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF,  1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h5555,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA,  1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF,  1'b0, 1'b0, 1'b0, 16'h0000, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    foreach (dir_rows[i])
      send_flux(dir_rows[i].flux, dir_rows[i].start, dir_rows[i].typed,
                dir_rows[i].has_word, dir_rows[i].word, dir_rows[i].synced);
    run_random(250);

    // tightest window, then the widest
    set_phase(0, 16'h4489);
    run_random(150);
    set_phase(39, 16'h4489);
    run_random(150);

    // zero pattern matches on empty cells: several words per item, some dropped
    set_phase(20, 16'h0000);
    run_random(100);

    // all-ones pattern, only reachable by long single-cell runs
    set_phase($urandom_range(39), 16'hFFFF);
    run_random(100);

    set_phase($urandom_range(39), ftm_pkg::WORD_W'($urandom_range(65535)));
    run_random(100);

    // back to defaults, with a stretch of back-to-back traffic on both sides
    set_phase(10, 16'h4489);
    quiet = 1'b1;
    run_random(150);
    quiet = 1'b0;
    run_random(100);

    settle();
    repeat (SETTLE) @(posedge clk_i);
    if (words_due.size() != 0) begin
      $error("%0d expected items never arrived", words_due.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("** flux_to_mfm_word_decoder_unit: PASSED **");
    else
      $display("** flux_to_mfm_word_decoder_unit: FAILED **");
    $finish;
  end

endmodule
